FILE: hdl/assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// Each macro expects the signals aclk and aresetn in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that an antecedent implies a consequent on the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spq_pkg.sv
// Shared types and codes for the sorted insert priority queue.
// Used by spq_cell and sorted_insert_priority_queue; depends on nothing.
package spq_pkg;

    // Request kinds carried on the input word's tuser.
    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_DEQUEUE = 1'b1
    } req_t;

    // Outcome codes carried on the result word's tuser.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2
    } status_t;

    // Fixed field widths of the stream words.
    localparam int FIELD_PRIO_W  = 8;
    localparam int FIELD_CHAR_W  = 8;
    localparam int FIELD_COUNT_W = 5;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

FILE: hdl/spq_cell.sv
// One cell of the sorted register row: holds a single (priority, character) entry.
// Depends on spq_pkg for the control struct and field widths.
module spq_cell #(
    parameter int PRIO_W = 8
) (
    input  logic                              aclk,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic                              occupied,
    input  logic                              prev_stay,
    input  logic [PRIO_W-1:0]                 new_prio,
    input  logic [spq_pkg::FIELD_CHAR_W-1:0]  new_chr,
    input  logic [PRIO_W-1:0]                 prev_prio,
    input  logic [spq_pkg::FIELD_CHAR_W-1:0]  prev_chr,
    input  logic [PRIO_W-1:0]                 next_prio,
    input  logic [spq_pkg::FIELD_CHAR_W-1:0]  next_chr,
    output logic                              stay,
    output logic [PRIO_W-1:0]                 prio,
    output logic [spq_pkg::FIELD_CHAR_W-1:0]  chr
);

    logic [PRIO_W-1:0]                prio_reg;
    logic [PRIO_W-1:0]                prio_next;
    logic [spq_pkg::FIELD_CHAR_W-1:0] chr_reg;
    logic [spq_pkg::FIELD_CHAR_W-1:0] chr_next;

    // An occupied entry at or below the new priority keeps its place.
    assign stay = occupied && (prio_reg <= new_prio);

    // Insert takes the new entry at the boundary and shifts the rest toward the tail;
    // removal shifts every entry one cell toward the head.
    always_comb begin
        prio_next = prio_reg;
        chr_next  = chr_reg;
        if (ctrl.enq && !stay) begin
            if (prev_stay) begin
                prio_next = new_prio;
                chr_next  = new_chr;
            end else begin
                prio_next = prev_prio;
                chr_next  = prev_chr;
            end
        end else if (ctrl.deq) begin
            prio_next = next_prio;
            chr_next  = next_chr;
        end
    end

    // Entry payload needs no reset: only occupied cells are ever read.
    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        chr_reg  <= chr_next;
    end

    assign prio = prio_reg;
    assign chr  = chr_reg;

endmodule

FILE: hdl/sorted_insert_priority_queue.sv
// Top level of the sorted insert priority queue: a row of spq_cell entries kept in order.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
//
//  Channel  Ports          Payload
//  input    s_axis_*       tuser: req_type; tdata: in_prio, in_char
//  result   m_axis_*       tuser: status; tdata: out_prio, out_char, entry_count,
//                          is_empty, is_full
//
// For every request, all cells compare against the new priority and
// shift in parallel, so one word is accepted per cycle while the result register
// is free or being emptied. Each accepted word gives its result on the next cycle.
// Reset clears the occupancy count and the result valid flag.
// A stalled result holds the input back only until it is taken.
`include "assert_macros.svh"

module sorted_insert_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] in_prio, [15:8] in_char
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_prio, [15:8] out_char,
                                        // [20:16] entry_count, [21] is_empty,
                                        // [22] is_full, [23] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int PRIO_W  = (PRIO_BITS < spq_pkg::FIELD_PRIO_W) ? PRIO_BITS
                                                                  : spq_pkg::FIELD_PRIO_W;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CHAR_W  = spq_pkg::FIELD_CHAR_W;

    logic                           s_fire;
    spq_pkg::req_t                  req;
    logic [PRIO_W-1:0]              new_prio;
    logic [CHAR_W-1:0]              new_chr;
    logic                           enq_ok;
    logic                           deq_ok;
    spq_pkg::cell_ctrl_t            ctrl;

    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;

    logic                           m_valid_reg;
    spq_pkg::status_t               status_reg;
    spq_pkg::status_t               status_next;
    logic [PRIO_W-1:0]              oprio_reg;
    logic [CHAR_W-1:0]              ochar_reg;
    logic [COUNT_W-1:0]             ocount_reg;

    logic [DEPTH-1:0]               stay;
    logic [PRIO_W-1:0]              cell_prio [DEPTH];
    logic [CHAR_W-1:0]              cell_chr  [DEPTH];

    // Input handshake and field unpacking.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign req           = spq_pkg::req_t'(s_axis_tuser);
    assign new_prio      = s_axis_tdata[PRIO_W-1:0];
    assign new_chr       = s_axis_tdata[spq_pkg::FIELD_PRIO_W +: CHAR_W];

    // Decide whether the request changes the row.
    assign enq_ok   = (req == spq_pkg::REQ_ENQUEUE) && (count_reg < COUNT_W'(DEPTH));
    assign deq_ok   = (req == spq_pkg::REQ_DEQUEUE) && (count_reg != '0);
    assign ctrl.enq = s_fire && enq_ok;
    assign ctrl.deq = s_fire && deq_ok;

    always_comb begin
        count_next  = count_reg;
        status_next = spq_pkg::STATUS_OK;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next = count_reg - 1'b1;
        end
        if (req == spq_pkg::REQ_ENQUEUE && !enq_ok) begin
            status_next = spq_pkg::STATUS_FULL;
        end else if (req == spq_pkg::REQ_DEQUEUE && !deq_ok) begin
            status_next = spq_pkg::STATUS_EMPTY;
        end
    end

    // The row of cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              occupied;
        logic              prev_stay;
        logic [PRIO_W-1:0] prev_prio;
        logic [CHAR_W-1:0] prev_chr;
        logic [PRIO_W-1:0] next_prio;
        logic [CHAR_W-1:0] next_chr;

        assign occupied = count_reg > COUNT_W'(i);

        if (i == 0) begin : g_head
            assign prev_stay = 1'b1;
            assign prev_prio = new_prio;
            assign prev_chr  = new_chr;
        end else begin : g_body
            assign prev_stay = stay[i-1];
            assign prev_prio = cell_prio[i-1];
            assign prev_chr  = cell_chr[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_prio = cell_prio[i];
            assign next_chr  = cell_chr[i];
        end else begin : g_inner
            assign next_prio = cell_prio[i+1];
            assign next_chr  = cell_chr[i+1];
        end

        spq_cell #(
            .PRIO_W (PRIO_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .prev_stay (prev_stay),
            .new_prio  (new_prio),
            .new_chr   (new_chr),
            .prev_prio (prev_prio),
            .prev_chr  (prev_chr),
            .next_prio (next_prio),
            .next_chr  (next_chr),
            .stay      (stay[i]),
            .prio      (cell_prio[i]),
            .chr       (cell_chr[i])
        );
    end

    // Occupancy count and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word payload, loaded on every accepted request.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            ocount_reg <= count_next;
            oprio_reg  <= ctrl.deq ? cell_prio[0] : '0;
            ochar_reg  <= ctrl.deq ? cell_chr[0] : '0;
        end
    end

    // Result word packing.
    assign m_axis_tvalid       = m_valid_reg;
    assign m_axis_tuser        = status_reg;
    assign m_axis_tdata[7:0]   = spq_pkg::FIELD_PRIO_W'(oprio_reg);
    assign m_axis_tdata[15:8]  = ochar_reg;
    assign m_axis_tdata[20:16] = spq_pkg::FIELD_COUNT_W'(ocount_reg);
    assign m_axis_tdata[21]    = (ocount_reg == '0);
    assign m_axis_tdata[22]    = (ocount_reg == COUNT_W'(DEPTH));
    assign m_axis_tdata[23]    = 1'b0;

    // The occupancy never goes beyond the number of cells.
    `SPQ_ASSERT(a_count_bound, count_reg <= COUNT_W'(DEPTH), "occupancy above depth")
    // An accepted insert grows the occupancy by exactly one.
    `SPQ_ASSERT_NEXT(a_enq_count, ctrl.enq, count_reg == $past(count_reg) + 1'b1,
        "insert did not grow occupancy")
    // Every accepted request leaves a result pending on the next cycle.
    `SPQ_ASSERT_NEXT(a_result_follows, s_fire, m_valid_reg, "accepted request gave no result")
    // The two cells nearest the head stay in priority order.
    `SPQ_ASSERT(a_head_sorted, (count_reg < 2) || (cell_prio[0] <= cell_prio[1]),
        "head cells out of order")

endmodule
